@@ hw/rtl/alu16_pkg.sv @@
// alu16_pkg: operation codes, flag record and shared code width for the 16-bit ALU
// with flags; used by the channel interfaces and the top level
// no dependencies
package alu16_pkg;

  localparam int FUNC_W = 3;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_MOV = 3'd0;
  localparam logic [FUNC_W-1:0] FN_ADD = 3'd1;
  localparam logic [FUNC_W-1:0] FN_INC = 3'd2;
  localparam logic [FUNC_W-1:0] FN_SUB = 3'd3;
  localparam logic [FUNC_W-1:0] FN_MUL = 3'd4;
  localparam logic [FUNC_W-1:0] FN_DIV = 3'd5;

  // flag register contents
  typedef struct packed {
    logic wrap;
    logic sign;
    logic zero;
  } flags_t;

endpackage

@@ hw/rtl/alu16_if.sv @@
// alu16_if: valid/ready channel interfaces for ALU requests and responses
// depends on alu16_pkg
interface alu16_req_if #(
  parameter int DATA_WIDTH = 16
) ();
  logic                          valid;
  logic                          ready;
  logic [alu16_pkg::FUNC_W-1:0]  func;
  logic [DATA_WIDTH-1:0]         operand_a;
  logic [DATA_WIDTH-1:0]         operand_b;
  logic [DATA_WIDTH-1:0]         dest_in;

  modport source (output valid, func, operand_a, operand_b, dest_in, input ready);
  modport sink   (input valid, func, operand_a, operand_b, dest_in, output ready);
endinterface

interface alu16_rsp_if #(
  parameter int DATA_WIDTH = 16
) ();
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] result;
  logic [DATA_WIDTH-1:0] remainder;
  logic                  wrap_flag;
  logic                  sign_flag;
  logic                  zero_flag;
  logic                  div_error;

  modport source (output valid, result, remainder, wrap_flag, sign_flag, zero_flag,
                  div_error, input ready);
  modport sink   (input valid, result, remainder, wrap_flag, sign_flag, zero_flag,
                  div_error, output ready);
endinterface

@@ hw/rtl/alu16_with_flags_unit.sv @@
// alu16_with_flags_unit: integer ALU step with a flag register, built around one
// shared adder/subtractor driven by a small sequencer
// depends on alu16_pkg and alu16_if
//
//   channel  role    carries
//   req      sink    func, operand_a, operand_b, dest_in
//   rsp      source  result, remainder, wrap_flag, sign_flag, zero_flag, div_error
//
// mov, add, inc and sub pass through S_FIX and S_DONE before response valid rises;
// mul and div first run the one-bit-per-cycle shift-add and restoring-divide loops
// through the shared adder, and div also passes S_FLAG after S_FIX.
// Mul by zero and divide by zero skip the loop and S_FIX and go straight to S_DONE.
// req.ready rises at the same edge as response valid; a finished response waits
// in the output register, and the sequencer holds the next one until rsp is taken.
// Reset clears the flag register.
module alu16_with_flags_unit #(
  parameter int DATA_WIDTH = 16
) (
  input logic          clk,
  input logic          rst,
  alu16_req_if.sink    req,
  alu16_rsp_if.source  rsp
);
  import alu16_pkg::*;

  localparam int CNT_W = $clog2(DATA_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);
  localparam logic [DATA_WIDTH:0] HALF =
    (DATA_WIDTH+1)'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_FIX, S_FLAG, S_DONE} state_t;

  state_t                state;
  logic [CNT_W-1:0]      cnt;
  logic [FUNC_W-1:0]     func_r;
  logic [DATA_WIDTH-1:0] a_r, b_r, d_r;
  logic [DATA_WIDTH-1:0] acc;       // product accumulator
  logic [DATA_WIDTH-1:0] shx;       // shifted multiplicand, or dividend/quotient
  logic [DATA_WIDTH-1:0] shy;       // shifted multiplier
  logic [DATA_WIDTH-1:0] rem_r;
  logic [DATA_WIDTH-1:0] res_r;
  logic                  derr_r;
  logic                  flag_upd;
  flags_t                flags_new;
  flags_t                flag_store;
  flags_t                flags_fin;

  logic                  rsp_valid;
  logic [DATA_WIDTH-1:0] rsp_result, rsp_remainder;
  flags_t                rsp_flags;
  logic                  rsp_derr;

  // shared adder/subtractor, one bit wider for the divide compare
  logic [DATA_WIDTH:0]   add_x, add_y;
  logic                  add_sub;
  logic [DATA_WIDTH+1:0] add_sum;
  logic [DATA_WIDTH-1:0] sum_lo;
  logic                  no_borrow;

  // flags of a flag-setting addition: first addend x, wrapped sum s
  function automatic flags_t flags_of(input logic [DATA_WIDTH:0] x,
                                      input logic [DATA_WIDTH-1:0] s,
                                      input logic with_sign);
    flags_t f;
    f.wrap = (s != '0) && ({1'b0, s} < HALF) && (x > HALF);
    f.sign = with_sign & s[DATA_WIDTH-1];
    f.zero = (s == '0);
    return f;
  endfunction

  // operand selection for the shared unit
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    case (state)
      S_MUL: begin
        add_x = {1'b0, acc};
        add_y = shy[0] ? {1'b0, shx} : '0;
      end
      S_DIV: begin
        add_x   = {rem_r, shx[DATA_WIDTH-1]};
        add_y   = {1'b0, b_r};
        add_sub = 1'b1;
      end
      S_FIX: begin
        case (func_r)
          FN_ADD: begin
            add_x = {1'b0, a_r};
            add_y = {1'b0, b_r};
          end
          FN_SUB: begin
            add_x   = {1'b0, a_r};
            add_y   = {1'b0, b_r};
            add_sub = 1'b1;
          end
          FN_INC: begin
            add_x = {1'b0, d_r};
            add_y = (DATA_WIDTH+1)'(1);
          end
          FN_MUL: begin
            add_x   = {1'b0, acc};
            add_y   = {1'b0, a_r};
            add_sub = 1'b1;
          end
          FN_DIV: begin
            add_x = {1'b0, d_r};
            add_y = {1'b0, shx};
          end
          default: ;
        endcase
      end
      S_FLAG: begin
        add_x = {1'b0, rem_r};
        add_y = {1'b0, b_r};
      end
      default: ;
    endcase
  end

  assign add_sum   = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
                     + (DATA_WIDTH+2)'(add_sub);
  assign sum_lo    = add_sum[DATA_WIDTH-1:0];
  assign no_borrow = add_sum[DATA_WIDTH+1];

  assign flags_fin = flag_upd ? flags_new : flag_store;

  // sequencer, flag register and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      flag_store <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      // response taken with no new one loaded behind it
      if (rsp_valid && rsp.ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            func_r   <= req.func;
            a_r      <= req.operand_a;
            b_r      <= req.operand_b;
            d_r      <= req.dest_in;
            acc      <= req.dest_in;
            shx      <= req.operand_a;
            shy      <= req.operand_b;
            rem_r    <= '0;
            res_r    <= req.dest_in;
            derr_r   <= (req.func == FN_DIV) && (req.operand_b == '0);
            flag_upd <= 1'b0;
            cnt      <= '0;
            if (req.func == FN_MUL) begin
              state <= (req.operand_b == '0) ? S_DONE : S_MUL;
            end else if (req.func == FN_DIV) begin
              state <= (req.operand_b == '0) ? S_DONE : S_DIV;
            end else begin
              state <= S_FIX;
            end
          end
        end
        // one multiplier bit per cycle
        S_MUL: begin
          acc <= sum_lo;
          shx <= shx << 1;
          shy <= shy >> 1;
          cnt <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            state <= S_FIX;
          end
        end
        // restoring divide, one quotient bit per cycle
        S_DIV: begin
          rem_r <= no_borrow ? sum_lo : add_x[DATA_WIDTH-1:0];
          shx   <= {shx[DATA_WIDTH-2:0], no_borrow};
          cnt   <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            state <= S_FIX;
          end
        end
        // final result; flags for add, sub, inc and mul
        S_FIX: begin
          state <= (func_r == FN_DIV) ? S_FLAG : S_DONE;
          case (func_r)
            FN_MOV: res_r <= a_r;
            FN_ADD, FN_SUB: begin
              res_r     <= sum_lo;
              flags_new <= flags_of({1'b0, a_r}, sum_lo, 1'b0);
              flag_upd  <= 1'b1;
            end
            FN_INC: begin
              res_r     <= sum_lo;
              flags_new <= flags_of({1'b0, d_r}, sum_lo, 1'b1);
              flag_upd  <= 1'b1;
            end
            FN_MUL: begin
              // previous partial sum is product minus one multiplicand
              res_r     <= acc;
              flags_new <= flags_of({1'b0, sum_lo}, acc, 1'b0);
              flag_upd  <= 1'b1;
            end
            FN_DIV: begin
              res_r <= sum_lo;
            end
            default: res_r <= d_r;
          endcase
        end
        // divide flags come from the last subtraction, first addend rem + b
        S_FLAG: begin
          flags_new <= flags_of(add_sum[DATA_WIDTH:0], rem_r, 1'b0);
          flag_upd  <= (shx != '0);
          state     <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid     <= 1'b1;
            rsp_result    <= res_r;
            rsp_remainder <= rem_r;
            rsp_flags     <= flags_fin;
            rsp_derr      <= derr_r;
            flag_store    <= flags_fin;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = rsp_valid;
  assign rsp.result    = rsp_result;
  assign rsp.remainder = rsp_remainder;
  assign rsp.wrap_flag = rsp_flags.wrap;
  assign rsp.sign_flag = rsp_flags.sign;
  assign rsp.zero_flag = rsp_flags.zero;
  assign rsp.div_error = rsp_derr;

  // partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem_r < b_r))
    else $error("partial remainder not below divisor");

  // loop counter starts from zero after each transfer
  a_cnt_start: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (cnt == '0))
    else $error("loop counter not cleared on transfer");

  // only increment may set the sign flag
  a_sign_inc: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && flag_upd && flags_new.sign) |-> (func_r == FN_INC))
    else $error("sign flag set by an operation other than increment");

  // divide by zero reports a zero remainder
  a_derr_rem: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.div_error) |-> (rsp.remainder == '0))
    else $error("nonzero remainder on divide by zero");

endmodule

@@ tb/alu16_flags_checker.sv @@
`timescale 1ns / 100ps
// alu16_flags_checker: watches the request and response channels of the 16-bit alu,
// predicts every response from its own copy of the flag register and compares
// depends on alu16_pkg and alu16_if
module alu16_flags_checker #(
  parameter int W = 16
) (
  input  logic        clk,
  input  logic        rst,
  alu16_req_if        req,
  alu16_rsp_if        rsp,
  output int          fail_count,
  output int          outstanding,
  output int          checked_count,
  output int          div_err_count
);
  import alu16_pkg::*;

  typedef logic [W-1:0] word_t;

  typedef struct packed {
    word_t  result;
    word_t  remainder;
    flags_t flags;
    logic   div_error;
  } alu_outcome_t;

  // largest value that still counts as positive, 0x7FFF at 16 bits
  localparam logic [W:0] HALF = (W+1)'((64'd1 << (W - 1)) - 64'd1);
  localparam int MAX_REPORTS = 60;

  flags_t       flag_copy;
  alu_outcome_t pending_results[$];
  alu_outcome_t exp_o;

  initial begin
    fail_count    = 0;
    outstanding   = 0;
    checked_count = 0;
    div_err_count = 0;
    flag_copy     = '0;
  end

  // flags of a flag-setting addition: first addend x, wrapped sum s
  function automatic flags_t sum_flags(logic [W:0] x, word_t s, logic with_sign);
    flags_t f;
    f.wrap = (s != '0) && ({1'b0, s} < HALF) && (x > HALF);
    f.sign = with_sign & s[W-1];
    f.zero = (s == '0);
    return f;
  endfunction

  // one alu step as seen from outside: new destination, remainder, flags
  function automatic alu_outcome_t alu_predict(logic [FUNC_W-1:0] op, word_t a, word_t b,
                                               word_t d, flags_t cur);
    alu_outcome_t   o;
    logic [2*W-1:0] prod;
    word_t          prev;
    word_t          quot;
    o.result    = d;
    o.remainder = '0;
    o.flags     = cur;
    o.div_error = 1'b0;
    case (op)
      FN_MOV: begin
        o.result = a;
      end
      FN_ADD: begin
        o.result = a + b;
        o.flags  = sum_flags({1'b0, a}, o.result, 1'b0);
      end
      FN_INC: begin
        o.result = d + 1'b1;
        o.flags  = sum_flags({1'b0, d}, o.result, 1'b1);
      end
      FN_SUB: begin
        o.result = a - b;
        o.flags  = sum_flags({1'b0, a}, o.result, 1'b0);
      end
      FN_MUL: begin
        // flags follow the last of b repeated additions of a
        if (b != '0) begin
          prod     = a * (b - 1'b1);
          prev     = d + prod[W-1:0];
          o.result = prev + a;
          o.flags  = sum_flags({1'b0, prev}, o.result, 1'b0);
        end
      end
      FN_DIV: begin
        if (b == '0) begin
          o.div_error = 1'b1;
        end else begin
          quot        = a / b;
          o.remainder = a % b;
          o.result    = d + quot;
          // last subtraction takes r + b down to r; none happens for a zero quotient
          if (quot != '0) o.flags = sum_flags({1'b0, o.remainder} + {1'b0, b},
                                              o.remainder, 1'b0);
        end
      end
      default: begin
      end
    endcase
    return o;
  endfunction

  task automatic check_field(string name, word_t want, word_t got);
    if (want !== got) begin
      if (fail_count < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // response transfer is checked before a request transfer at the same edge is predicted
  always @(posedge clk) begin
    if (rst) begin
      flag_copy = '0;
      pending_results.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          if (fail_count < MAX_REPORTS)
            $display("%0t: response with none expected, actual result %h", $time,
                     rsp.result);
          fail_count++;
        end else begin
          exp_o = pending_results.pop_front();
          check_field("result", exp_o.result, rsp.result);
          check_field("remainder", exp_o.remainder, rsp.remainder);
          check_field("wrap_flag", W'(exp_o.flags.wrap), W'(rsp.wrap_flag));
          check_field("sign_flag", W'(exp_o.flags.sign), W'(rsp.sign_flag));
          check_field("zero_flag", W'(exp_o.flags.zero), W'(rsp.zero_flag));
          check_field("div_error", W'(exp_o.div_error), W'(rsp.div_error));
          checked_count++;
        end
      end
      if (req.valid && req.ready) begin
        exp_o     = alu_predict(req.func, req.operand_a, req.operand_b, req.dest_in,
                                flag_copy);
        flag_copy = exp_o.flags;
        pending_results.push_back(exp_o);
        if (exp_o.div_error) div_err_count++;
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

@@ tb/tb_alu16_with_flags_unit.sv @@
`timescale 1ns / 100ps
// tb_alu16_with_flags_unit: drives directed and random alu requests with random idling
// on both channels, and gives the verdict from the checker's failure and outstanding counts
// depends on alu16_pkg, alu16_if, alu16_with_flags_unit and alu16_flags_checker
module tb_alu16_with_flags_unit;
  import alu16_pkg::*;

  localparam int W = 16;
  localparam logic [FUNC_W-1:0] FN_RSVD6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_RSVD7 = 3'd7;
  localparam int PHASE_ITEMS  = 410;
  localparam int LONG_STALL   = 300;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 40;

  typedef logic [W-1:0] word_t;

  logic clk;
  logic rst;

  alu16_req_if #(.DATA_WIDTH(W)) req_ch ();
  alu16_rsp_if #(.DATA_WIDTH(W)) rsp_ch ();

  int fail_count;
  int outstanding;
  int checked_count;
  int div_err_count;
  int sent_count;
  int src_idle_pct;
  int sink_idle_pct;
  int stall_req;
  int stall_seen;
  int stall_left;
  int idle_cycles;

  alu16_with_flags_unit #(.DATA_WIDTH(W)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  alu16_flags_checker #(.W(W)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .checked_count (checked_count),
    .div_err_count (div_err_count)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // response side: random back-pressure, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (stall_req != stall_seen) begin
      stall_seen = stall_req;
      stall_left = LONG_STALL - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // one request transfer; entered and left at a falling edge
  task automatic send_op(logic [FUNC_W-1:0] op, word_t a, word_t b, word_t d);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.func      <= op;
    req_ch.operand_a <= a;
    req_ch.operand_b <= b;
    req_ch.dest_in   <= d;
    do @(posedge clk); while (!req_ch.ready);
    sent_count++;
    @(negedge clk);
  endtask

  // stop offering and wait for every outstanding response
  task automatic pause_until_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    @(negedge clk);
  endtask

  // operand values weighted toward the boundaries
  function automatic word_t pick_word();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h7FFF;
      3:       return 16'h8000;
      4:       return W'($urandom_range(16));
      default: return W'($urandom);
    endcase
  endfunction

  task automatic send_random(int count);
    logic [FUNC_W-1:0] op;
    word_t             b;
    repeat (count) begin
      op = FUNC_W'($urandom_range(7));
      if ($urandom_range(3) == 0) op = $urandom_range(1) ? FN_MUL : FN_DIV;
      b = pick_word();
      // small divisors give non-zero quotients more often
      if (op == FN_DIV && $urandom_range(1) == 0) b = W'($urandom_range(300));
      send_op(op, pick_word(), b, pick_word());
    end
  endtask

  initial begin
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.func      = FN_MOV;
    req_ch.operand_a = '0;
    req_ch.operand_b = '0;
    req_ch.dest_in   = '0;
    rsp_ch.ready     = 1'b0;
    sent_count       = 0;
    stall_req        = 0;
    stall_seen       = 0;
    stall_left       = 0;
    idle_cycles      = 0;
    src_idle_pct     = 10;
    sink_idle_pct    = 69;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: boundary operands, every operation, the no-effect cases
    send_op(FN_MOV, 16'hFFFF, 16'h0000, 16'h0000);
    send_op(FN_ADD, 16'h0000, 16'h0000, 16'h0000);
    send_op(FN_ADD, 16'hFFFF, 16'h0001, 16'h1111);
    send_op(FN_ADD, 16'h8000, 16'h8001, 16'h0000);
    send_op(FN_ADD, 16'h7FFF, 16'h7FFF, 16'h0000);
    send_op(FN_ADD, 16'hFFFF, 16'h7FFF, 16'hFFFF);
    send_op(FN_MOV, 16'h1234, 16'hFFFF, 16'hFFFF);
    send_op(FN_INC, 16'h0000, 16'h0000, 16'h7FFF);
    send_op(FN_INC, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_op(FN_INC, 16'h0000, 16'h0000, 16'h8000);
    send_op(FN_SUB, 16'h0005, 16'h0005, 16'h0000);
    send_op(FN_SUB, 16'h0000, 16'h0001, 16'h0000);
    send_op(FN_SUB, 16'h8000, 16'h0001, 16'h0000);
    send_op(FN_SUB, 16'hFFFF, 16'h8001, 16'h0000);
    // multiply by zero keeps destination and flags
    send_op(FN_MUL, 16'hFFFF, 16'h0000, 16'hABCD);
    send_op(FN_MUL, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_op(FN_MUL, 16'h0003, 16'h0005, 16'h0001);
    // divide by zero raises the error
    send_op(FN_DIV, 16'h1234, 16'h0000, 16'h5555);
    // quotient zero keeps the flags
    send_op(FN_DIV, 16'h0004, 16'h0009, 16'h0010);
    send_op(FN_DIV, 16'hFFFF, 16'h0001, 16'h0000);
    send_op(FN_DIV, 16'h0064, 16'h0007, 16'hFFFF);
    send_op(FN_DIV, 16'h0000, 16'h0005, 16'h0000);
    send_op(FN_DIV, 16'hFFFF, 16'hFFFF, 16'h7FFF);
    // unused codes leave the destination alone
    send_op(FN_RSVD6, 16'hFFFF, 16'hFFFF, 16'h00FF);
    send_op(FN_RSVD7, 16'h0000, 16'h0000, 16'hFF00);

    // sender rarely idles, receiver mostly stalls
    send_random(PHASE_ITEMS);
    pause_until_drained();

    // long receiver hold-off while requests keep coming
    stall_req++;
    send_random(12);
    pause_until_drained();

    src_idle_pct  = 69;
    sink_idle_pct = 10;
    send_random(PHASE_ITEMS);
    pause_until_drained();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    send_random(PHASE_ITEMS);
    pause_until_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d requests sent, %0d responses checked, %0d of them divide by zero",
             sent_count, checked_count, div_err_count);
    $display("three idling mixes plus one %0d-cycle response hold-off", LONG_STALL);
    if (fail_count == 0 && outstanding == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
